// ===== rtl/rv32s_pkg.sv =====
// Shared types, constants and helpers for the RV32 subset core.
// Used by the byte store, the register file and the top level; no dependencies.
package rv32s_pkg;

    // Memory geometry: byte stores split into four byte lanes (power-of-two size)
    localparam int MEM_BYTES = 1024;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int ROWS      = MEM_BYTES / 4;
    localparam int ROW_AW    = MEM_AW - 2;
    localparam int NREGS     = 32;
    localparam int CLR_N     = (ROWS > NREGS) ? ROWS : NREGS;
    localparam int CLR_W     = $clog2(CLR_N);

    typedef logic [MEM_AW-1:0] t_maddr;
    typedef logic [ROW_AW-1:0] t_row;
    typedef logic [4:0]        t_ridx;
    typedef logic [31:0]       t_word;

    typedef enum logic [1:0] {
        CMD_STEP   = 2'd0,
        CMD_LOAD_I = 2'd1,
        CMD_LOAD_D = 2'd2,
        CMD_READ_D = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_DEC,
        S_EXE,
        S_MEM,
        S_DONE
    } t_state;

    localparam logic [6:0] OP_LOAD    = 7'h03;
    localparam logic [6:0] OP_ADDI    = 7'h13;
    localparam logic [6:0] OP_STORE   = 7'h23;
    localparam logic [6:0] OP_ALU     = 7'h33;
    localparam logic [6:0] OP_HALT    = 7'h7F;
    localparam logic [6:0] FUNCT7_SUB = 7'h20;
    localparam t_word      SIGN_FILL  = 32'hFFFFF000;

    // Request to a byte store: word read, word write, byte write or clear row
    typedef struct packed {
        logic       rd;
        logic       wr_word;
        logic       wr_byte;
        logic       clr;
        t_maddr     addr;
        t_row       clr_row;
        t_word      wdata;
        logic [7:0] wbyte;
    } t_mem_req;

    // Request to the register file: two reads, one write
    typedef struct packed {
        logic  rd;
        t_ridx ra;
        t_ridx rb;
        logic  we;
        t_ridx wa;
        t_word wd;
    } t_rf_req;

    function automatic t_word sext12(logic [11:0] v);
        t_word r;
        r = {20'b0, v};
        if (v[11]) begin
            r = r | SIGN_FILL;
        end
        return r;
    endfunction

    function automatic t_maddr to_maddr(logic [9:0] a);
        return t_maddr'(a);
    endfunction

endpackage

// ===== rtl/rv32s_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and held while the read enable is low; no dependencies.
module rv32s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rv32s_bytemem.sv =====
// Byte-addressed store built from four byte-lane RAMs; big-endian word access
// at any byte address with wrap. Depends on rv32s_pkg and rv32s_ram.
module rv32s_bytemem
    import rv32s_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_word    o_rdata
);

    logic [7:0] w_q [4];
    logic [1:0] r_off;

    // Lane b holds byte (b - addr) mod 4 of the word starting at addr
    for (genvar b = 0; b < 4; b++) begin : g_lane
        logic [1:0] sel;
        t_maddr     ba;
        t_word      wsh;
        logic       we;
        t_row       wrow;
        logic [7:0] wd;

        assign sel = 2'(b) - i_req.addr[1:0];
        assign ba  = i_req.addr + t_maddr'(sel);
        assign wsh = i_req.wdata >> {~sel, 3'b000};

        always_comb begin
            we   = 1'b0;
            wrow = ba[MEM_AW-1:2];
            wd   = i_req.wbyte;
            if (i_req.clr) begin
                we   = 1'b1;
                wrow = i_req.clr_row;
                wd   = '0;
            end else if (i_req.wr_word) begin
                we = 1'b1;
                wd = wsh[7:0];
            end else if (i_req.wr_byte && (i_req.addr[1:0] == 2'(b))) begin
                we = 1'b1;
            end
        end

        rv32s_ram #(
            .WIDTH(8),
            .DEPTH(ROWS)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (we),
            .i_waddr(wrow),
            .i_wdata(wd),
            .i_re   (i_req.rd),
            .i_raddr(ba[MEM_AW-1:2]),
            .o_rdata(w_q[b])
        );
    end

    // Lane offset of the word being read, for reassembly
    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_off <= i_req.addr[1:0];
        end
    end

    // Byte 0 (lowest address) lands in bits 31..24
    always_comb begin
        logic [1:0] k;
        o_rdata = '0;
        for (int i = 0; i < 4; i++) begin
            k = r_off + 2'(i);
            o_rdata[31-8*i -: 8] = w_q[k];
        end
    end

endmodule

// ===== rtl/rv32s_regfile.sv =====
// 32 x 32 register file as two RAM copies for two reads per cycle; x0 reads zero.
// Depends on rv32s_pkg and rv32s_ram.
module rv32s_regfile
    import rv32s_pkg::*;
(
    input  logic    i_clk,
    input  t_rf_req i_req,
    output t_word   o_a,
    output t_word   o_b
);

    t_word w_qa;
    t_word w_qb;
    logic  r_a0;
    logic  r_b0;

    rv32s_ram #(
        .WIDTH(32),
        .DEPTH(NREGS)
    ) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (i_req.we),
        .i_waddr(i_req.wa),
        .i_wdata(i_req.wd),
        .i_re   (i_req.rd),
        .i_raddr(i_req.ra),
        .o_rdata(w_qa)
    );

    rv32s_ram #(
        .WIDTH(32),
        .DEPTH(NREGS)
    ) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (i_req.we),
        .i_waddr(i_req.wa),
        .i_wdata(i_req.wd),
        .i_re   (i_req.rd),
        .i_raddr(i_req.rb),
        .o_rdata(w_qb)
    );

    // Remember x0 reads so they come back as zero
    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_a0 <= (i_req.ra == '0);
            r_b0 <= (i_req.rb == '0);
        end
    end

    assign o_a = r_a0 ? '0 : w_qa;
    assign o_b = r_b0 ? '0 : w_qb;

endmodule

// ===== rtl/rv32_subset_single_cycle_core.sv =====
// Top level of the RV32 subset core: sequencer, ALU and output register.
// Depends on rv32s_pkg, rv32s_bytemem and rv32s_regfile.
//
// Usage
//   Input channel (i_valid / o_stall) carries one command word: step one
//   instruction, load an instruction byte, load a data byte or read a data byte.
//   Output channel (o_valid / i_stall) returns one result word per command:
//   pc, halted and retired after the command, plus write-back, store and
//   read-byte information.
//   Sequence: a byte load or read command goes from acceptance straight to
//   delivery. A step passes through fetch from the instruction lanes,
//   register-file read, execute and deliver; LW adds a data-lane read before
//   delivery. A step while halted goes straight to delivery.
//   Commands are processed one at a time.
//   Reset: a clearing pass writes zero to every row of both byte stores and to
//   the register file, with o_stall high throughout.
//   Output stall: the result sits in the output register; a new command may be
//   accepted and worked on, and its result waits until the register is taken.
module rv32_subset_single_cycle_core
    import rv32s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [9:0]  i_mem_addr,
    input  logic [7:0]  i_mem_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_pc,
    output logic        o_halted,
    output logic        o_reg_written,
    output logic [4:0]  o_reg_index,
    output logic [31:0] o_reg_value,
    output logic        o_store_done,
    output logic [7:0]  o_read_byte,
    output logic [31:0] o_retired
);

    // Control state
    t_state     r_state, n_state;
    logic [CLR_W-1:0] r_clr, n_clr;
    t_word      r_pc, n_pc;
    logic       r_halt, n_halt;
    t_word      r_retired, n_retired;

    // Per-command payload
    t_cmd       r_cmd, n_cmd;
    t_word      r_ins, n_ins;
    logic       r_wrote, n_wrote;
    t_ridx      r_widx, n_widx;
    t_word      r_wval, n_wval;
    logic       r_stored, n_stored;

    // Output register
    logic       r_ovalid;
    t_word      r_o_pc;
    logic       r_o_halted;
    logic       r_o_wrote;
    t_ridx      r_o_widx;
    t_word      r_o_wval;
    logic       r_o_stored;
    logic [7:0] r_o_rbyte;
    t_word      r_o_retired;
    logic       out_load;

    t_mem_req   imem_req;
    t_mem_req   dmem_req;
    t_rf_req    rf_req;
    t_word      imem_rdata;
    t_word      dmem_rdata;
    t_word      rf_a;
    t_word      rf_b;

    // Execute datapath
    logic [6:0] op;
    t_ridx      rd;
    t_word      imm_i;
    t_word      imm_s;
    t_word      opb;
    logic       cin;
    t_word      sum;
    t_word      pc_next;

    rv32s_bytemem u_imem (
        .i_clk  (i_clk),
        .i_req  (imem_req),
        .o_rdata(imem_rdata)
    );

    rv32s_bytemem u_dmem (
        .i_clk  (i_clk),
        .i_req  (dmem_req),
        .o_rdata(dmem_rdata)
    );

    rv32s_regfile u_rf (
        .i_clk(i_clk),
        .i_req(rf_req),
        .o_a  (rf_a),
        .o_b  (rf_b)
    );

    assign o_stall = (r_state != S_IDLE);

    // Shared adder: address for LW/SW, ADDI, ADD and SUB
    assign op    = r_ins[6:0];
    assign rd    = r_ins[11:7];
    assign imm_i = sext12(r_ins[31:20]);
    assign imm_s = sext12({r_ins[31:25], r_ins[11:7]});

    always_comb begin
        opb = imm_i;
        cin = 1'b0;
        case (op)
            OP_LOAD, OP_ADDI: opb = imm_i;
            OP_STORE:         opb = imm_s;
            OP_ALU: begin
                if (r_ins[31:25] == FUNCT7_SUB) begin
                    opb = ~rf_b;
                    cin = 1'b1;
                end else begin
                    opb = rf_b;
                end
            end
            default:          opb = imm_i;
        endcase
    end

    assign sum     = rf_a + opb + {31'b0, cin};
    assign pc_next = (op == OP_HALT) ? r_pc : r_pc + 32'd4;

    // Sequencer: next state and memory requests
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_pc      = r_pc;
        n_halt    = r_halt;
        n_retired = r_retired;
        n_cmd     = r_cmd;
        n_ins     = r_ins;
        n_wrote   = r_wrote;
        n_widx    = r_widx;
        n_wval    = r_wval;
        n_stored  = r_stored;
        imem_req  = '0;
        dmem_req  = '0;
        rf_req    = '0;
        out_load  = 1'b0;

        case (r_state)
            S_CLR: begin
                if (32'(r_clr) < ROWS) begin
                    imem_req.clr     = 1'b1;
                    imem_req.clr_row = r_clr[ROW_AW-1:0];
                    dmem_req.clr     = 1'b1;
                    dmem_req.clr_row = r_clr[ROW_AW-1:0];
                end
                if (32'(r_clr) < NREGS) begin
                    rf_req.we = 1'b1;
                    rf_req.wa = r_clr[4:0];
                    rf_req.wd = '0;
                end
                n_clr = r_clr + CLR_W'(1);
                if (r_clr == CLR_W'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = t_cmd'(i_command);
                    n_wrote  = 1'b0;
                    n_widx   = '0;
                    n_wval   = '0;
                    n_stored = 1'b0;
                    n_state  = S_DONE;
                    case (t_cmd'(i_command))
                        CMD_STEP: begin
                            if (!r_halt) begin
                                imem_req.rd   = 1'b1;
                                imem_req.addr = t_maddr'(r_pc);
                                n_state       = S_DEC;
                            end
                        end
                        CMD_LOAD_I: begin
                            imem_req.wr_byte = 1'b1;
                            imem_req.addr    = to_maddr(i_mem_addr);
                            imem_req.wbyte   = i_mem_byte;
                        end
                        CMD_LOAD_D: begin
                            dmem_req.wr_byte = 1'b1;
                            dmem_req.addr    = to_maddr(i_mem_addr);
                            dmem_req.wbyte   = i_mem_byte;
                        end
                        CMD_READ_D: begin
                            dmem_req.rd   = 1'b1;
                            dmem_req.addr = to_maddr(i_mem_addr);
                        end
                        default: ;
                    endcase
                end
            end

            // Instruction word is back: read both source registers
            S_DEC: begin
                n_ins     = imem_rdata;
                rf_req.rd = 1'b1;
                rf_req.ra = imem_rdata[19:15];
                rf_req.rb = imem_rdata[24:20];
                n_state   = S_EXE;
            end

            // Execute and commit, except LW which waits for data
            S_EXE: begin
                if (op == OP_LOAD) begin
                    dmem_req.rd   = 1'b1;
                    dmem_req.addr = t_maddr'(sum);
                    n_state       = S_MEM;
                end else begin
                    case (op)
                        OP_ADDI, OP_ALU: begin
                            if (rd != '0) begin
                                rf_req.we = 1'b1;
                                rf_req.wa = rd;
                                rf_req.wd = sum;
                                n_wrote   = 1'b1;
                                n_widx    = rd;
                                n_wval    = sum;
                            end
                        end
                        OP_STORE: begin
                            dmem_req.wr_word = 1'b1;
                            dmem_req.addr    = t_maddr'(sum);
                            dmem_req.wdata   = rf_b;
                            n_stored         = 1'b1;
                        end
                        OP_HALT: n_halt = 1'b1;
                        default: ;
                    endcase
                    n_pc      = pc_next;
                    n_retired = r_retired + 32'd1;
                    n_state   = S_DONE;
                end
            end

            // Load data is back: write back and commit
            S_MEM: begin
                if (rd != '0) begin
                    rf_req.we = 1'b1;
                    rf_req.wa = rd;
                    rf_req.wd = dmem_rdata;
                    n_wrote   = 1'b1;
                    n_widx    = rd;
                    n_wval    = dmem_rdata;
                end
                n_pc      = pc_next;
                n_retired = r_retired + 32'd1;
                n_state   = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_pc      <= '0;
            r_halt    <= 1'b0;
            r_retired <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_pc      <= n_pc;
            r_halt    <= n_halt;
            r_retired <= n_retired;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_ins    <= n_ins;
        r_wrote  <= n_wrote;
        r_widx   <= n_widx;
        r_wval   <= n_wval;
        r_stored <= n_stored;
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_pc      <= r_pc;
            r_o_halted  <= r_halt;
            r_o_wrote   <= r_wrote;
            r_o_widx    <= r_widx;
            r_o_wval    <= r_wval;
            r_o_stored  <= r_stored;
            r_o_rbyte   <= (r_cmd == CMD_READ_D) ? dmem_rdata[31:24] : 8'd0;
            r_o_retired <= r_retired;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_pc          = r_o_pc;
    assign o_halted      = r_o_halted;
    assign o_reg_written = r_o_wrote;
    assign o_reg_index   = r_o_widx;
    assign o_reg_value   = r_o_wval;
    assign o_store_done  = r_o_stored;
    assign o_read_byte   = r_o_rbyte;
    assign o_retired     = r_o_retired;

    // Checks
    a_retire_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXE) && (op != OP_LOAD) |=> r_retired == $past(r_retired) + 32'd1)
        else $error("retired count did not advance on commit");

    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !r_ovalid)
        else $error("result presented during clearing pass");

    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_req.we && (r_state != S_CLR) |-> (rf_req.wa != '0))
        else $error("write-back to x0");

    a_halt_freezes_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_pc == $past(r_pc))
        else $error("pc moved while halted");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rv32_subset_single_cycle_core: loads programs byte by byte,
// steps them and checks every result against an in-bench model of the core.
// Depends on rv32s_pkg and the core RTL only.
module testbench;
    import rv32s_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_WORDS  = 600;

    // One result word as it leaves the core, in port order
    typedef struct packed {
        t_word      pc;
        logic       halted;
        logic       reg_written;
        t_ridx      reg_index;
        t_word      reg_value;
        logic       store_done;
        logic [7:0] read_byte;
        t_word      retired;
    } t_core_result;

    // Architectural model of the core plus the queue of results still owed
    class core_scoreboard;
        logic [7:0]   instr_mem [MEM_BYTES];
        logic [7:0]   data_mem [MEM_BYTES];
        t_word        regs [NREGS];
        t_word        pc;
        logic         halted;
        t_word        retired;
        t_maddr       last_data_addr;
        t_core_result owed [$];
        int           errors;
        int           results_seen;

        function new();
            foreach (instr_mem[i]) instr_mem[i] = 8'h00;
            foreach (data_mem[i]) data_mem[i] = 8'h00;
            foreach (regs[i]) regs[i] = '0;
            pc             = '0;
            halted         = 1'b0;
            retired        = '0;
            last_data_addr = '0;
            errors         = 0;
            results_seen   = 0;
        endfunction

        // Big-endian word, each byte address wrapping on its own
        function t_word gather(bit from_data, t_word base);
            t_word  w;
            t_maddr ix;
            w = '0;
            for (int k = 0; k < 4; k++) begin
                ix = t_maddr'(base + k);
                w  = {w[23:0], from_data ? data_mem[ix] : instr_mem[ix]};
            end
            return w;
        endfunction

        // Accepted command word: update the model and queue its result
        function void note_input(t_cmd cmd, logic [9:0] addr, logic [7:0] data);
            t_core_result res;
            t_word        ins, a, b, val, ea;
            logic [6:0]   opc;
            t_ridx        rd;
            bit           wen;
            res = '0;
            case (cmd)
                CMD_LOAD_I: instr_mem[t_maddr'(addr)] = data;
                CMD_LOAD_D: data_mem[t_maddr'(addr)] = data;
                CMD_READ_D: res.read_byte = data_mem[t_maddr'(addr)];
                default: begin
                    if (!halted) begin
                        ins = gather(1'b0, pc);
                        opc = ins[6:0];
                        rd  = ins[11:7];
                        a   = regs[ins[19:15]];
                        b   = regs[ins[24:20]];
                        val = '0;
                        wen = 1'b0;
                        case (opc)
                            OP_LOAD: begin
                                ea  = a + {{20{ins[31]}}, ins[31:20]};
                                val = gather(1'b1, ea);
                                wen = 1'b1;
                                last_data_addr = t_maddr'(ea);
                            end
                            OP_ADDI: begin
                                val = a + {{20{ins[31]}}, ins[31:20]};
                                wen = 1'b1;
                            end
                            OP_STORE: begin
                                ea = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
                                for (int k = 0; k < 4; k++)
                                    data_mem[t_maddr'(ea + k)] = b[31-8*k -: 8];
                                res.store_done = 1'b1;
                                last_data_addr = t_maddr'(ea);
                            end
                            OP_ALU: begin
                                val = (ins[31:25] == FUNCT7_SUB) ? a - b : a + b;
                                wen = 1'b1;
                            end
                            default: ;
                        endcase
                        // x0 stays zero: writes to it are dropped
                        if (wen && rd != 5'd0) begin
                            regs[rd]        = val;
                            res.reg_written = 1'b1;
                            res.reg_index   = rd;
                            res.reg_value   = val;
                        end
                        if (opc == OP_HALT) halted = 1'b1;
                        else pc = pc + 32'd4;
                        retired = retired + 32'd1;
                    end
                end
            endcase
            res.pc      = pc;
            res.halted  = halted;
            res.retired = retired;
            owed.push_back(res);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("ERROR: %s", msg);
        endfunction

        function void diff(string name, t_word want, t_word got);
            if (want !== got)
                flag($sformatf("%s mismatch on result %0d: expected %h, got %h",
                               name, results_seen, want, got));
        endfunction

        // Accepted result word: compare with the oldest one owed
        function void check_result(t_core_result got);
            t_core_result want;
            results_seen++;
            if (owed.size() == 0) begin
                flag($sformatf("result %0d arrived with nothing owed", results_seen));
                return;
            end
            want = owed.pop_front();
            diff("pc", want.pc, got.pc);
            diff("halted", 32'(want.halted), 32'(got.halted));
            diff("reg_written", 32'(want.reg_written), 32'(got.reg_written));
            diff("reg_index", 32'(want.reg_index), 32'(got.reg_index));
            diff("reg_value", want.reg_value, got.reg_value);
            diff("store_done", 32'(want.store_done), 32'(got.store_done));
            diff("read_byte", 32'(want.read_byte), 32'(got.read_byte));
            diff("retired", want.retired, got.retired);
        endfunction

        function void close_out();
            if (owed.size() != 0)
                flag($sformatf("%0d results never arrived", owed.size()));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_command;
    logic [9:0]  i_mem_addr;
    logic [7:0]  i_mem_byte;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_pc;
    logic        o_halted;
    logic        o_reg_written;
    logic [4:0]  o_reg_index;
    logic [31:0] o_reg_value;
    logic        o_store_done;
    logic [7:0]  o_read_byte;
    logic [31:0] o_retired;

    core_scoreboard sb;
    int             words_sent;

    rv32_subset_single_cycle_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_mem_addr    (i_mem_addr),
        .i_mem_byte    (i_mem_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pc          (o_pc),
        .o_halted      (o_halted),
        .o_reg_written (o_reg_written),
        .o_reg_index   (o_reg_index),
        .o_reg_value   (o_reg_value),
        .o_store_done  (o_store_done),
        .o_read_byte   (o_read_byte),
        .o_retired     (o_retired)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Instruction encoders
    function automatic t_word enc_i(logic [11:0] imm, t_ridx rs1, logic [2:0] f3,
                                    t_ridx rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic t_word enc_s(logic [11:0] imm, t_ridx rs2, t_ridx rs1,
                                    logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic t_word enc_r(logic [6:0] f7, t_ridx rs2, t_ridx rs1,
                                    logic [2:0] f3, t_ridx rd);
        return {f7, rs2, rs1, f3, rd, OP_ALU};
    endfunction

    // Mostly the low registers, so values flow between instructions
    function automatic t_ridx pick_reg();
        return ($urandom_range(3) == 0) ? t_ridx'($urandom_range(31))
                                        : t_ridx'($urandom_range(7));
    endfunction

    // Random instruction of any kind except halt
    function automatic t_word random_instr();
        t_word      raw;
        logic [6:0] opc;
        raw = $urandom;
        case ($urandom_range(9))
            0, 1, 2: return enc_i(raw[31:20], pick_reg(), raw[14:12], pick_reg(), OP_ADDI);
            3, 4:    return enc_i(raw[31:20], pick_reg(), raw[14:12], pick_reg(), OP_LOAD);
            5, 6:    return enc_s(raw[31:20], pick_reg(), pick_reg(), raw[14:12]);
            7, 8:    return enc_r($urandom_range(1) ? FUNCT7_SUB : raw[31:25], pick_reg(),
                                  pick_reg(), raw[14:12], pick_reg());
            default: begin
                opc = raw[6:0];
                while (opc inside {OP_LOAD, OP_ADDI, OP_STORE, OP_ALU, OP_HALT})
                    opc = 7'($urandom);
                return {raw[31:7], opc};
            end
        endcase
    endfunction

    // Offer one command word; returns at the falling edge after acceptance
    task automatic send_word(t_cmd cmd, logic [9:0] addr, logic [7:0] data);
        bit calm;
        calm = (words_sent >= 250 && words_sent < 350);
        while (!calm && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_mem_addr <= addr;
        i_mem_byte <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(cmd, addr, data);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Write an instruction at the current PC and step it
    task automatic put_instr(t_word ins);
        for (int k = 0; k < 4; k++)
            send_word(CMD_LOAD_I, 10'(sb.pc + k), ins[31-8*k -: 8]);
        send_word(CMD_STEP, 10'($urandom), 8'($urandom));
    endtask

    // Result side: random stalls, one long hold-off, and a stretch with none
    initial begin : result_stall_gen
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && sb.results_seen >= 150) begin
                held      = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (sb.results_seen >= 300 && sb.results_seen < 420) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 19);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_pc, o_halted, o_reg_written, o_reg_index, o_reg_value,
                             o_store_done, o_read_byte, o_retired});
    end

    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge i_clk);
        $display("rv32_subset_single_cycle_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        int         pick;
        logic [7:0] ibyte;
        sb         = new();
        words_sent = 0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_command  = CMD_STEP;
        i_mem_addr = '0;
        i_mem_byte = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, wrap of data words, every operation but halt, x0 write
        send_word(CMD_LOAD_D, 10'd1023, 8'hFF);
        send_word(CMD_LOAD_D, 10'd0, 8'h80);
        send_word(CMD_STEP, 10'h3FF, 8'hFF);                        // empty store: unknown op
        put_instr(enc_i(12'h800, 5'd0, 3'd7, 5'd1, OP_ADDI));       // most negative imm
        put_instr(enc_i(12'hFFF, 5'd0, 3'd2, 5'd2, OP_LOAD));       // word wraps past top
        put_instr(enc_s(12'h7FF, 5'd1, 5'd0, 3'd2));                // store wraps too
        send_word(CMD_READ_D, 10'd1023, 8'h00);
        put_instr(enc_r(FUNCT7_SUB, 5'd1, 5'd2, 3'd0, 5'd31));
        put_instr(enc_r(7'h00, 5'd31, 5'd1, 3'd5, 5'd0));           // x0 write dropped

        // Random: mostly programs, with data traffic and noise
        while (words_sent < RAND_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                put_instr(random_instr());
            end else if (pick < 77) begin
                send_word(CMD_LOAD_D, 10'($urandom), 8'($urandom));
            end else if (pick < 89) begin
                send_word(CMD_READ_D,
                          $urandom_range(1) ? 10'(sb.last_data_addr + $urandom_range(3))
                                            : 10'($urandom),
                          8'($urandom));
            end else if (pick < 94) begin
                send_word(CMD_STEP, 10'($urandom), 8'($urandom));
            end else begin
                // stray instruction byte; never one that could decode as halt
                ibyte = 8'($urandom);
                if (ibyte[6:0] == OP_HALT) ibyte[0] = 1'b0;
                send_word(CMD_LOAD_I, 10'($urandom), ibyte);
            end
        end

        // Halt, then steps and memory traffic while halted
        put_instr({25'($urandom), OP_HALT});
        send_word(CMD_STEP, 10'($urandom), 8'($urandom));
        send_word(CMD_LOAD_D, 10'd5, 8'h5A);
        send_word(CMD_READ_D, 10'd5, 8'h00);
        send_word(CMD_STEP, 10'($urandom), 8'($urandom));

        i_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("rv32_subset_single_cycle_core regression: pass");
        else
            $display("rv32_subset_single_cycle_core regression: fail");
        $finish;
    end
endmodule
